>>> hw/rtl/csc_pkg.sv
// Shared types and constants for the color sort eject sequencer.
package csc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROXIMITY_MIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_PERCENT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_STOP_DELAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_DELAY    = 3'd5;

	// Action codes of an input transaction.
	localparam logic [1:0] ACT_TICK         = 2'd0;
	localparam logic [1:0] ACT_TOGGLE_RUN   = 2'd1;
	localparam logic [1:0] ACT_TOGGLE_COLOR = 2'd2;

	localparam logic [6:0] DRIVE_FULL  = 7'd127;
	localparam logic [6:0] DRIVE_OFF   = 7'd0;
	localparam logic [8:0] HUE_RED_HI  = 9'd30;
	localparam logic [8:0] HUE_BLUE_LO = 9'd150;
	localparam logic [8:0] HUE_BLUE_HI = 9'd230;
	localparam logic [6:0] RATIO_SCALE = 7'd100;

	typedef enum logic [1:0] {
		PH_POLL   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_STOP   = 2'd2,
		PH_SETTLE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  poll_interval;
		logic [7:0]  proximity_min;
		logic [6:0]  ratio_percent;
		logic [15:0] lift_stop_delay;
		logic [15:0] stop_time;
		logic [15:0] resume_delay;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		poll_interval:   8'd3,
		proximity_min:   8'd75,
		ratio_percent:   7'd30,
		lift_stop_delay: 16'd55,
		stop_time:       16'd300,
		resume_delay:    16'd200
	};

	typedef struct packed {
		logic [6:0] intake_drive;
		logic [6:0] lift_drive;
		logic       sorting_on;
		logic       eject_busy;
	} res_t;

endpackage

>>> hw/rtl/csc_item_if.sv
// Input channel: one tick with an optical sample, or a button event.
interface csc_item_if #(
	parameter int COLOR_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             action;
	logic [7:0]             proximity;
	logic [8:0]             hue;
	logic [COLOR_WIDTH-1:0] red;
	logic [COLOR_WIDTH-1:0] blue;

	modport source (output valid, action, proximity, hue, red, blue, input ready);
	modport sink (input valid, action, proximity, hue, red, blue, output ready);
endinterface

>>> hw/rtl/csc_result_if.sv
// Output channel: motor commands and status after each input transaction.
interface csc_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] intake_drive;
	logic [6:0] lift_drive;
	logic       sorting_on;
	logic       eject_busy;

	modport source (output valid, intake_drive, lift_drive, sorting_on, eject_busy, input ready);
	modport sink (input valid, intake_drive, lift_drive, sorting_on, eject_busy, output ready);
endinterface

>>> hw/rtl/csc_classify.sv
// Sample classifier: proximity gate, hue window and red/blue dominance test.
module csc_classify import csc_pkg::*; #(
	parameter int COLOR_WIDTH = 16
) (
	input  logic [7:0]             proximity,
	input  logic [8:0]             hue,
	input  logic [COLOR_WIDTH-1:0] red,
	input  logic [COLOR_WIDTH-1:0] blue,
	input  logic                   reject_blue,
	input  cfg_t                   cfg,
	output logic                   hit
);
	localparam int PW = COLOR_WIDTH + 7;

	logic                   red_lt_blue;
	logic                   blue_lt_red;
	logic [COLOR_WIDTH-1:0] big;
	logic [COLOR_WIDTH-1:0] little;
	logic [PW-1:0]          little_scaled;
	logic [PW-1:0]          big_scaled;
	logic                   ratio_ok;
	logic                   in_blue_win;
	logic                   in_red_win;
	logic                   rejected;

	assign red_lt_blue = red < blue;
	assign blue_lt_red = blue < red;
	assign big    = blue_lt_red ? red : blue;
	assign little = blue_lt_red ? blue : red;

	// Exact integer form of little/big >= ratio/100.
	assign little_scaled = PW'(little) * PW'(RATIO_SCALE);
	assign big_scaled    = PW'(big) * PW'(cfg.ratio_percent);
	assign ratio_ok      = little_scaled >= big_scaled;

	assign in_blue_win = (hue >= HUE_BLUE_LO) && (hue <= HUE_BLUE_HI);
	assign in_red_win  = hue <= HUE_RED_HI;

	assign rejected = reject_blue ? (in_blue_win || (red_lt_blue && ratio_ok))
	                              : (in_red_win || (blue_lt_red && ratio_ok));

	assign hit = (proximity > cfg.proximity_min) && rejected;
endmodule

>>> hw/rtl/csc_core.sv
// Sequencer state: run/color flags, poll counter and the timed eject phases.
module csc_core import csc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] action,
	input  logic       hit,
	input  cfg_t       cfg,
	output logic       reject_blue,
	output res_t       res
);
	logic        running_q, running_d;
	logic        reject_blue_q, reject_blue_d;
	phase_t      phase_q, phase_d;
	phase_t      phase_next;
	logic [15:0] timer_q, timer_d;
	logic [15:0] timer_inc;
	logic [15:0] phase_len;
	logic [7:0]  poll_q, poll_d;
	logic [7:0]  poll_inc;

	assign timer_inc = timer_q + 16'd1;
	assign poll_inc  = poll_q + 8'd1;

	always_comb begin
		unique case (phase_q)
			PH_WAIT: begin
				phase_len  = cfg.lift_stop_delay;
				phase_next = PH_STOP;
			end
			PH_STOP: begin
				phase_len  = cfg.stop_time;
				phase_next = PH_SETTLE;
			end
			PH_SETTLE: begin
				phase_len  = cfg.resume_delay;
				phase_next = PH_POLL;
			end
			default: begin
				phase_len  = cfg.resume_delay;
				phase_next = PH_POLL;
			end
		endcase
	end

	always_comb begin
		running_d     = running_q;
		reject_blue_d = reject_blue_q;
		phase_d       = phase_q;
		timer_d       = timer_q;
		poll_d        = poll_q;
		unique case (action)
			ACT_TICK: begin
				if (running_q) begin
					if (phase_q != PH_POLL) begin
						// At most one phase advance per tick.
						if (timer_inc >= phase_len) begin
							timer_d = '0;
							phase_d = phase_next;
							if (phase_next == PH_POLL) begin
								poll_d = '0;
							end
						end else begin
							timer_d = timer_inc;
						end
					end else if (poll_inc >= cfg.poll_interval) begin
						poll_d = '0;
						if (hit) begin
							phase_d = PH_WAIT;
							timer_d = '0;
						end
					end else begin
						poll_d = poll_inc;
					end
				end
			end
			ACT_TOGGLE_RUN: begin
				// Turning sorting off aborts any eject in progress.
				running_d = !running_q;
				phase_d   = PH_POLL;
				timer_d   = '0;
				poll_d    = '0;
			end
			ACT_TOGGLE_COLOR: begin
				reject_blue_d = !reject_blue_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			reject_blue_q <= 1'b1;
			phase_q       <= PH_POLL;
			timer_q       <= '0;
			poll_q        <= '0;
		end else if (step) begin
			running_q     <= running_d;
			reject_blue_q <= reject_blue_d;
			phase_q       <= phase_d;
			timer_q       <= timer_d;
			poll_q        <= poll_d;
		end
	end

	assign reject_blue = reject_blue_q;

	assign res.intake_drive = running_d ? DRIVE_FULL : DRIVE_OFF;
	assign res.lift_drive   = (running_d && (phase_d != PH_STOP)) ? DRIVE_FULL : DRIVE_OFF;
	assign res.sorting_on   = running_d;
	assign res.eject_busy   = phase_d != PH_POLL;
endmodule

>>> hw/rtl/color_sort_eject_sequencer.sv
// A result passes through the input register and then the result register after its input
// transaction is accepted; result.ready held low can keep it waiting in either register.
// Throughput: one transaction per cycle unless result.ready stalls; classification and the state
// update sit between the input register and the result register, and the state loop closes there.
// Reset (arst_n low, asynchronous): sorting off, blue rejected, polling phase,
// counters cleared, registers at their defaults, both pipeline stages empty.
// Top level of the color sort eject sequencer.
module color_sort_eject_sequencer import csc_pkg::*; #(
	parameter int COLOR_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	csc_item_if.sink              item,
	csc_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	cfg_t                   cfg_q;
	logic                   item_valid_s1;
	logic [1:0]             action_s1;
	logic [7:0]             proximity_s1;
	logic [8:0]             hue_s1;
	logic [COLOR_WIDTH-1:0] red_s1;
	logic [COLOR_WIDTH-1:0] blue_s1;
	logic                   res_valid_s2;
	res_t                   res_s2;
	res_t                   res_next;
	logic                   reject_blue;
	logic                   hit;
	logic                   adv_s2;
	logic                   fire_s1;
	logic                   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLL_INTERVAL:   cfg_q.poll_interval   <= cfg_wdata[7:0];
				REG_PROXIMITY_MIN:   cfg_q.proximity_min   <= cfg_wdata[7:0];
				REG_RATIO_PERCENT:   cfg_q.ratio_percent   <= cfg_wdata[6:0];
				REG_LIFT_STOP_DELAY: cfg_q.lift_stop_delay <= cfg_wdata;
				REG_STOP_TIME:       cfg_q.stop_time       <= cfg_wdata;
				REG_RESUME_DELAY:    cfg_q.resume_delay    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The result register frees up when empty or being taken this cycle.
	assign adv_s2     = !res_valid_s2 || result.ready;
	assign fire_s1    = item_valid_s1 && adv_s2;
	assign item.ready = !item_valid_s1 || adv_s2;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take) begin
			item_valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1    <= item.action;
			proximity_s1 <= item.proximity;
			hue_s1       <= item.hue;
			red_s1       <= item.red;
			blue_s1      <= item.blue;
		end
	end

	csc_classify #(
		.COLOR_WIDTH (COLOR_WIDTH)
	) u_classify (
		.proximity   (proximity_s1),
		.hue         (hue_s1),
		.red         (red_s1),
		.blue        (blue_s1),
		.reject_blue (reject_blue),
		.cfg         (cfg_q),
		.hit         (hit)
	);

	csc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (fire_s1),
		.action      (action_s1),
		.hit         (hit),
		.cfg         (cfg_q),
		.reject_blue (reject_blue),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid        = res_valid_s2;
	assign result.intake_drive = res_s2.intake_drive;
	assign result.lift_drive   = res_s2.lift_drive;
	assign result.sorting_on   = res_s2.sorting_on;
	assign result.eject_busy   = res_s2.eject_busy;

	// An eject can only be running while sorting is on.
	a_busy_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.eject_busy |-> res_s2.sorting_on)
		else $error("eject reported busy while sorting is off");

	// With sorting on, the lift only stops inside an eject.
	a_lift_stop_in_eject: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.sorting_on && (res_s2.lift_drive == DRIVE_OFF)
		|-> res_s2.eject_busy)
		else $error("lift stopped outside an eject sequence");

	// Intake command tracks the sorting flag.
	a_intake_tracks_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> ((res_s2.intake_drive == DRIVE_FULL) == res_s2.sorting_on))
		else $error("intake command disagrees with sorting state");

	// An accepted transaction always lands in the input stage.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> item_valid_s1)
		else $error("accepted transaction lost before the input stage");
endmodule

>>> tb/color_sort_eject_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench for the color sort eject sequencer, checked against an in-bench predictor.
module color_sort_eject_sequencer_tb;
	import csc_pkg::*;

	localparam int          COLOR_W      = 16;
	localparam logic [1:0]  ACT_UNUSED   = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 100_000;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 6;

	// Tracks the sequencer state and holds the motor commands still to come.
	class sort_checker;
		cfg_t        regs;
		bit          running;
		bit          reject_blue;
		phase_t      stage;
		bit [15:0]   stage_timer;
		bit [7:0]    poll_count;
		res_t        pending[$];
		int unsigned errors;

		function new();
			regs        = CFG_RESET;
			running     = 1'b0;
			reject_blue = 1'b1;
			stage       = PH_POLL;
			stage_timer = '0;
			poll_count  = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_POLL_INTERVAL:   regs.poll_interval   = data[7:0];
				REG_PROXIMITY_MIN:   regs.proximity_min   = data[7:0];
				REG_RATIO_PERCENT:   regs.ratio_percent   = data[6:0];
				REG_LIFT_STOP_DELAY: regs.lift_stop_delay = data;
				REG_STOP_TIME:       regs.stop_time       = data;
				REG_RESUME_DELAY:    regs.resume_delay    = data;
				default: ;
			endcase
		endfunction

		function bit is_reject(logic [8:0] hue, logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] blue);
			int unsigned hi;
			int unsigned lo;
			bit          ratio_met;
			hi = (red > blue) ? red : blue;
			lo = (red > blue) ? blue : red;
			ratio_met = (lo * 32'd100) >= (hi * 32'(regs.ratio_percent));
			if (reject_blue)
				return (hue >= HUE_BLUE_LO && hue <= HUE_BLUE_HI) || (red < blue && ratio_met);
			return (hue <= HUE_RED_HI) || (blue < red && ratio_met);
		endfunction

		// One phase advance at most per tick, so a zero length still lasts a tick.
		function void advance_stage();
			bit [15:0] span;
			case (stage)
				PH_WAIT: span = regs.lift_stop_delay;
				PH_STOP: span = regs.stop_time;
				default: span = regs.resume_delay;
			endcase
			stage_timer = stage_timer + 16'd1;
			if (stage_timer >= span) begin
				stage_timer = '0;
				stage = (stage == PH_SETTLE) ? PH_POLL : phase_t'(stage + 2'd1);
				if (stage == PH_POLL)
					poll_count = '0;
			end
		endfunction

		function void note_item(logic [1:0] action, logic [7:0] prox, logic [8:0] hue,
				logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] blue);
			res_t want;
			case (action)
				ACT_TOGGLE_RUN: begin
					running     = !running;
					stage       = PH_POLL;
					stage_timer = '0;
					poll_count  = '0;
				end
				ACT_TOGGLE_COLOR: reject_blue = !reject_blue;
				ACT_TICK: begin
					if (running) begin
						if (stage != PH_POLL) begin
							advance_stage();
						end else begin
							poll_count = poll_count + 8'd1;
							if (poll_count >= regs.poll_interval) begin
								poll_count = '0;
								if (prox > regs.proximity_min && is_reject(hue, red, blue)) begin
									stage       = PH_WAIT;
									stage_timer = '0;
								end
							end
						end
					end
				end
				default: ;
			endcase
			want.intake_drive = running ? DRIVE_FULL : DRIVE_OFF;
			want.lift_drive   = (running && stage != PH_STOP) ? DRIVE_FULL : DRIVE_OFF;
			want.sorting_on   = running;
			want.eject_busy   = (stage != PH_POLL);
			pending.push_back(want);
		endfunction

		function void check_result(logic [6:0] intake, logic [6:0] lift, logic on_flag,
				logic busy);
			res_t want;
			if (pending.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (intake !== want.intake_drive) begin
				$error("intake_drive: expected %0d, actual %0d", want.intake_drive, intake);
				errors++;
			end
			if (lift !== want.lift_drive) begin
				$error("lift_drive: expected %0d, actual %0d", want.lift_drive, lift);
				errors++;
			end
			if (on_flag !== want.sorting_on) begin
				$error("sorting_on: expected %0d, actual %0d", want.sorting_on, on_flag);
				errors++;
			end
			if (busy !== want.eject_busy) begin
				$error("eject_busy: expected %0d, actual %0d", want.eject_busy, busy);
				errors++;
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	csc_item_if #(.COLOR_WIDTH(COLOR_W)) item_ch ();
	csc_result_if result_ch ();

	sort_checker sb;
	int unsigned cycle_count = 0;
	bit          hold_off_req = 1'b0;
	bit          pacing_on = 1'b1;
	int unsigned burst_left = 0;

	always #2 clk = ~clk;

	color_sort_eject_sequencer #(.COLOR_WIDTH(COLOR_W)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.intake_drive, result_ch.lift_drive,
				result_ch.sorting_on, result_ch.eject_busy);
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Result side: short stretches of always-ready, light or heavy stalls, and one long hold-off
	// when the stimulus asks for it.
	initial begin : result_sink
		int unsigned span;
		int unsigned mode;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(1, 40);
				repeat (span) begin
					case (mode)
						0:       result_ch.ready <= 1'b1;
						1:       result_ch.ready <= ($urandom_range(0, 2) != 0);
						default: result_ch.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic send_item(logic [1:0] action, logic [7:0] prox, logic [8:0] hue,
			logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] blue);
		int unsigned gap;
		if (pacing_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap != 0) begin
					item_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		item_ch.valid     <= 1'b1;
		item_ch.action    <= action;
		item_ch.proximity <= prox;
		item_ch.hue       <= hue;
		item_ch.red       <= red;
		item_ch.blue      <= blue;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(action, prox, hue, red, blue);
	endtask

	task automatic tick(logic [7:0] prox, logic [8:0] hue, logic [COLOR_W-1:0] red,
			logic [COLOR_W-1:0] blue);
		send_item(ACT_TICK, prox, hue, red, blue);
	endtask

	// The extra edge first lets the result monitor catch up with the last transaction.
	task automatic wait_results_done();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic load_settings(logic [7:0] poll, logic [7:0] prox_min, logic [6:0] ratio,
			logic [15:0] first, logic [15:0] stop, logic [15:0] resume);
		wait_results_done();
		set_reg(REG_POLL_INTERVAL, {8'd0, poll});
		set_reg(REG_PROXIMITY_MIN, {8'd0, prox_min});
		set_reg(REG_RATIO_PERCENT, {9'd0, ratio});
		set_reg(REG_LIFT_STOP_DELAY, first);
		set_reg(REG_STOP_TIME, stop);
		set_reg(REG_RESUME_DELAY, resume);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int unsigned count);
		logic [1:0]         act;
		logic [7:0]         prox;
		logic [8:0]         hue;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] blue;
		int unsigned        pick;
		int unsigned        hi;
		int unsigned        lo;
		int unsigned        cut;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (!sb.running && pick < 40)
				act = ACT_TOGGLE_RUN;
			else if (pick < 3)
				act = ACT_TOGGLE_RUN;
			else if (pick < 9)
				act = ACT_TOGGLE_COLOR;
			else if (pick < 11)
				act = ACT_UNUSED;
			else
				act = ACT_TICK;
			if ($urandom_range(0, 3) == 0)
				prox = 8'($urandom_range(0, 255));
			else
				prox = 8'($urandom_range(sb.regs.proximity_min, 255));
			case ($urandom_range(0, 3))
				0:       hue = 9'($urandom_range(HUE_BLUE_LO - 2, HUE_BLUE_HI + 2));
				1:       hue = 9'($urandom_range(0, HUE_RED_HI + 2));
				2:       hue = 9'($urandom_range(0, 511));
				default: hue = 9'($urandom_range(HUE_RED_HI + 1, HUE_BLUE_LO - 1));
			endcase
			red  = 16'($urandom);
			blue = 16'($urandom);
			case ($urandom_range(0, 5))
				// Smaller channel placed right at or just below the dominance threshold.
				0, 1: begin
					hi  = $urandom_range(1, 65535);
					cut = (hi * sb.regs.ratio_percent + 99) / 100;
					if (cut > 65535)
						cut = 65535;
					lo = (cut > 0 && $urandom_range(0, 1) == 1) ? cut - 1 : cut;
					if ($urandom_range(0, 1) == 1) begin
						red  = 16'(hi);
						blue = 16'(lo);
					end else begin
						red  = 16'(lo);
						blue = 16'(hi);
					end
				end
				2: begin
					red  = ($urandom_range(0, 1) == 1) ? 16'd0 : 16'hFFFF;
					blue = ($urandom_range(0, 1) == 1) ? 16'd0 : 16'hFFFF;
				end
				default: ;
			endcase
			send_item(act, prox, hue, red, blue);
		end
	endtask

	initial begin : stimulus
		sb = new();
		item_ch.valid     = 1'b0;
		item_ch.action    = ACT_TICK;
		item_ch.proximity = '0;
		item_ch.hue       = '0;
		item_ch.red       = '0;
		item_ch.blue      = '0;
		result_ch.ready   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through a full eject, the boundaries and the toggles.
		load_settings(8'd1, 8'd75, 7'd30, 16'd2, 16'd0, 16'd1);
		tick(8'd255, 9'd200, 16'd0, 16'hFFFF);
		send_item(ACT_UNUSED, 8'd255, 9'd511, 16'hFFFF, 16'hFFFF);
		send_item(ACT_TOGGLE_COLOR, 8'd0, 9'd0, 16'd0, 16'd0);
		send_item(ACT_TOGGLE_COLOR, 8'd0, 9'd0, 16'd0, 16'd0);
		send_item(ACT_TOGGLE_RUN, 8'd0, 9'd0, 16'd0, 16'd0);
		tick(8'd75, 9'd200, 16'd0, 16'd0);
		tick(8'd76, 9'd149, 16'd0, 16'd0);
		tick(8'd255, 9'd231, 16'hFFFF, 16'hFFFF);
		tick(8'd255, 9'd359, 16'd29, 16'd100);
		tick(8'd255, 9'd511, 16'd30, 16'd100);
		repeat (4) tick(8'd0, 9'd0, 16'd0, 16'd0);
		tick(8'd255, 9'd150, 16'd0, 16'd0);
		send_item(ACT_TOGGLE_COLOR, 8'd0, 9'd0, 16'd0, 16'd0);
		tick(8'd0, 9'd0, 16'd0, 16'd0);
		send_item(ACT_TOGGLE_RUN, 8'd0, 9'd0, 16'd0, 16'd0);
		send_item(ACT_TOGGLE_RUN, 8'd0, 9'd0, 16'd0, 16'd0);
		tick(8'd255, 9'd0, 16'd0, 16'd0);
		repeat (4) tick(8'd0, 9'd30, 16'd0, 16'd0);
		tick(8'd255, 9'd31, 16'd100, 16'd30);
		tick(8'd255, 9'd230, 16'd0, 16'd0);

		load_settings(8'd1, 8'd0, 7'd0, 16'd0, 16'd0, 16'd0);
		run_random(80);

		load_settings(8'd2, 8'd255, 7'd100, 16'd3, 16'd5, 16'd2);
		run_random(60);

		load_settings(8'($urandom_range(1, 4)), 8'($urandom_range(0, 200)),
			7'($urandom_range(0, 100)), 16'($urandom_range(0, 12)),
			16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
		run_random(50);
		// Hold the result side off while the input keeps pushing so the block backs up.
		hold_off_req = 1'b1;
		pacing_on = 1'b0;
		run_random(60);
		pacing_on = 1'b1;
		wait_results_done();
		run_random(50);

		load_settings(8'd0, 8'd128, 7'd127, 16'd5, 16'd3, 16'd4);
		run_random(60);

		load_settings(8'($urandom_range(1, 6)), 8'($urandom_range(0, 150)),
			7'($urandom_range(0, 100)), 16'($urandom_range(0, 20)),
			16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
		run_random(50);

		// One eject driven from detection back to polling with no gaps.
		load_settings(8'd3, 8'd0, 7'd50, 16'd12, 16'd9, 16'd10);
		pacing_on = 1'b0;
		if (!sb.running)
			send_item(ACT_TOGGLE_RUN, 8'd0, 9'd0, 16'd0, 16'd0);
		while (sb.stage == PH_POLL)
			tick(8'd255, sb.reject_blue ? HUE_BLUE_LO : 9'd0, 16'd0, 16'd0);
		while (sb.stage != PH_POLL)
			tick(8'($urandom), 9'($urandom), 16'($urandom), 16'($urandom));
		pacing_on = 1'b1;

		wait_results_done();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
